[hdl/ipd_pkg.sv]
// Shared types and constants for the incremental PID drive unit.
`default_nettype none
package ipd_pkg;
    localparam int DRIVE_BITS = 16;
    localparam int ACC_W      = DRIVE_BITS + 16;
    localparam int KW         = 52;
    localparam int KLO        = 26;
    localparam int PW         = 59;
    localparam int SW         = 88;
    localparam int DIV_STEPS  = 32;
    localparam int MUL_STEPS  = 6;

    localparam logic [DRIVE_BITS-1:0] DRIVE_MAX = {DRIVE_BITS{1'b1}};

    localparam logic [1:0] REG_GAIN_P = 2'd0;
    localparam logic [1:0] REG_GAIN_I = 2'd1;
    localparam logic [1:0] REG_GAIN_D = 2'd2;
    localparam logic [1:0] REG_START  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_COEF,
        ST_MUL,
        ST_ACC,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       div_step;
        logic       coef_load;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       acc_en;
        logic       commit;
    } cmd_t;

    typedef struct packed {
        logic restart;
    } stat_t;
endpackage
`default_nettype wire

[hdl/incremental_pid_drive_unit.sv]
// Top level: APB register file and the sequencer/datapath pair.
// Items are taken one at a time: in_stall holds until the last item commits its drive.
// A normal item runs the 32-step restoring divider for kd/T and the six-pass shared
//   27x32 multiplier; a restart item skips both.
// A finished drive waits in an output register while the next item is taken.
// Reset (rst_n low, asynchronous) clears gains, start drive, errors and accumulator.
`default_nettype none
module incremental_pid_drive_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       restart,
    input  wire logic signed [31:0]         target_rate,
    input  wire logic signed [31:0]         measured_rate,
    input  wire logic [15:0]                elapsed_ms,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [ipd_pkg::DRIVE_BITS-1:0]  drive,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [3:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [15:0]        start_reg;
    logic               wr;
    ipd_pkg::cmd_t      cmd;
    ipd_pkg::stat_t     stat;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            start_reg  <= '0;
        end
        else if (wr)
        begin
            unique case (paddr[3:2])
                ipd_pkg::REG_GAIN_P: gain_p_reg <= pwdata;
                ipd_pkg::REG_GAIN_I: gain_i_reg <= pwdata;
                ipd_pkg::REG_GAIN_D: gain_d_reg <= pwdata;
                ipd_pkg::REG_START:  start_reg  <= pwdata[15:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            ipd_pkg::REG_GAIN_P: prdata = gain_p_reg;
            ipd_pkg::REG_GAIN_I: prdata = gain_i_reg;
            ipd_pkg::REG_GAIN_D: prdata = gain_d_reg;
            ipd_pkg::REG_START:  prdata = {16'h0, start_reg};
            default:             prdata = '0;
        endcase
    end

    ipd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .restart   (restart),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    ipd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .restart       (restart),
        .target_rate   (target_rate),
        .measured_rate (measured_rate),
        .elapsed_ms    (elapsed_ms),
        .gain_p        (gain_p_reg),
        .gain_i        (gain_i_reg),
        .gain_d        (gain_d_reg),
        .start_drive   (start_reg),
        .stat          (stat),
        .drive         (drive)
    );
endmodule
`default_nettype wire

[hdl/ipd_ctrl.sv]
// Step sequencer for the incremental PID drive unit.
`default_nettype none
module ipd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          restart,
    input  wire logic          out_stall,
    input  wire ipd_pkg::stat_t stat,
    output logic               in_stall,
    output logic               out_valid,
    output ipd_pkg::cmd_t      cmd
);
    ipd_pkg::state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept, can_commit;

    assign accept     = in_valid && (state_reg == ipd_pkg::ST_IDLE);
    assign can_commit = !(out_valid_reg && out_stall);
    assign in_stall   = (state_reg != ipd_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ipd_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                    state_next = restart ? ipd_pkg::ST_FIN : ipd_pkg::ST_DIV;
            end
            ipd_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(ipd_pkg::DIV_STEPS - 1))
                begin
                    state_next = ipd_pkg::ST_COEF;
                    cnt_next   = '0;
                end
            end
            ipd_pkg::ST_COEF:
                state_next = ipd_pkg::ST_MUL;
            ipd_pkg::ST_MUL:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(ipd_pkg::MUL_STEPS - 1))
                    state_next = ipd_pkg::ST_ACC;
            end
            ipd_pkg::ST_ACC:
                state_next = ipd_pkg::ST_FIN;
            ipd_pkg::ST_FIN:
                if (can_commit)
                    state_next = ipd_pkg::ST_IDLE;
            default:
                state_next = ipd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.capture    = accept;
        cmd.div_step   = (state_reg == ipd_pkg::ST_DIV);
        cmd.coef_load  = (state_reg == ipd_pkg::ST_COEF);
        cmd.mul_en     = (state_reg == ipd_pkg::ST_MUL);
        cmd.mul_sel    = cnt_reg[2:0];
        cmd.acc_en     = ((state_reg == ipd_pkg::ST_MUL) && (cnt_reg != '0))
                         || (state_reg == ipd_pkg::ST_ACC);
        cmd.commit     = (state_reg == ipd_pkg::ST_FIN) && can_commit;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.commit)
            out_valid_next = 1'b1;
    end

    // restart status only steers the datapath; no extra control needed here
    logic unused_stat;
    assign unused_stat = stat.restart;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ipd_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

[hdl/ipd_dp.sv]
// Datapath: error, divider, coefficients, shared multiplier and accumulator.
`default_nettype none
module ipd_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ipd_pkg::cmd_t                 cmd,
    input  wire logic                          restart,
    input  wire logic signed [31:0]            target_rate,
    input  wire logic signed [31:0]            measured_rate,
    input  wire logic [15:0]                   elapsed_ms,
    input  wire logic signed [31:0]            gain_p,
    input  wire logic signed [31:0]            gain_i,
    input  wire logic signed [31:0]            gain_d,
    input  wire logic [15:0]                   start_drive,
    output ipd_pkg::stat_t                     stat,
    output logic [ipd_pkg::DRIVE_BITS-1:0]     drive
);
    logic                          rs_reg;
    logic signed [31:0]            e0_reg, e1_reg, e2_reg;
    logic [15:0]                   t_reg;
    logic [31:0]                   dvd_reg;
    logic [16:0]                   rem_reg;
    logic                          gneg_reg;
    logic signed [48:0]            pt_reg;
    logic signed [ipd_pkg::KW-1:0] a_reg, b_reg, c_reg;
    logic signed [ipd_pkg::PW-1:0] prod_reg;
    logic                          hi_reg;
    logic signed [ipd_pkg::SW-1:0] sum_reg;
    logic [ipd_pkg::ACC_W-1:0]     accum_reg, accum_next;
    logic [ipd_pkg::DRIVE_BITS-1:0] drive_reg;

    logic signed [32:0]            diff;
    logic signed [31:0]            e_sat;
    logic [16:0]                   rem_t;
    logic                          ge;
    logic signed [32:0]            dq;
    logic signed [ipd_pkg::KW-1:0] k_sel, dq_x;
    logic signed [31:0]            e_sel;
    logic signed [26:0]            m_op;
    logic signed [ipd_pkg::SW-1:0] addend, total, top;
    logic [31:0]                   sd32;
    logic [ipd_pkg::DRIVE_BITS-1:0] s_sat;

    assign stat.restart = rs_reg;
    assign drive        = drive_reg;

    always_comb
    begin
        diff = 33'(target_rate) - 33'(measured_rate);
        if (!diff[32] && diff[31])
            e_sat = 32'sh7FFF_FFFF;
        else if (diff[32] && !diff[31])
            e_sat = 32'sh8000_0000;
        else
            e_sat = diff[31:0];

        rem_t = {rem_reg[15:0], dvd_reg[31]};
        ge    = (rem_t >= {1'b0, t_reg});

        dq   = gneg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
        dq_x = ipd_pkg::KW'(dq);

        unique case (cmd.mul_sel[2:1])
            2'd0:    begin k_sel = a_reg; e_sel = e0_reg; end
            2'd1:    begin k_sel = b_reg; e_sel = e1_reg; end
            default: begin k_sel = c_reg; e_sel = e2_reg; end
        endcase
        if (cmd.mul_sel[0])
            m_op = 27'($signed(k_sel[ipd_pkg::KW-1:ipd_pkg::KLO]));
        else
            m_op = $signed({1'b0, k_sel[ipd_pkg::KLO-1:0]});

        addend = hi_reg ? (ipd_pkg::SW'(prod_reg) <<< ipd_pkg::KLO)
                        : ipd_pkg::SW'(prod_reg);

        sd32  = 32'(start_drive);
        s_sat = (sd32 > 32'(ipd_pkg::DRIVE_MAX)) ? ipd_pkg::DRIVE_MAX
                                                 : sd32[ipd_pkg::DRIVE_BITS-1:0];

        total = sum_reg + $signed({{(ipd_pkg::SW-ipd_pkg::ACC_W-16){1'b0}}, accum_reg, 16'h0});
        top   = $signed({{(ipd_pkg::SW-ipd_pkg::DRIVE_BITS-32){1'b0}},
                         ipd_pkg::DRIVE_MAX, 32'h0});
        if (rs_reg)
            accum_next = {s_sat, 16'h0};
        else if (total[ipd_pkg::SW-1])
            accum_next = '0;
        else if (total > top)
            accum_next = {ipd_pkg::DRIVE_MAX, 16'h0};
        else
            accum_next = total[ipd_pkg::ACC_W+15:16];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rs_reg   <= restart;
            e0_reg   <= e_sat;
            t_reg    <= (elapsed_ms == 16'd0) ? 16'd1 : elapsed_ms;
            dvd_reg  <= gain_d[31] ? 32'(-gain_d) : 32'(gain_d);
            gneg_reg <= gain_d[31];
            rem_reg  <= '0;
            sum_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? (rem_t - {1'b0, t_reg}) : rem_t;
            dvd_reg <= {dvd_reg[30:0], ge};
            pt_reg  <= 49'(gain_i) * 49'($signed({1'b0, t_reg}));
        end
        if (cmd.coef_load)
        begin
            a_reg <= ipd_pkg::KW'(gain_p) + dq_x;
            b_reg <= -ipd_pkg::KW'(gain_p) + ipd_pkg::KW'(pt_reg) - (dq_x <<< 1);
            c_reg <= dq_x;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= ipd_pkg::PW'(m_op) * ipd_pkg::PW'(e_sel);
            hi_reg   <= cmd.mul_sel[0];
        end
        if (cmd.acc_en)
            sum_reg <= sum_reg + addend;
        if (cmd.commit)
            drive_reg <= accum_next[ipd_pkg::ACC_W-1:16];
    end

    // loop state resets to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            e1_reg    <= '0;
            e2_reg    <= '0;
        end
        else if (cmd.commit)
        begin
            accum_reg <= accum_next;
            e1_reg    <= rs_reg ? 32'sd0 : e0_reg;
            e2_reg    <= rs_reg ? 32'sd0 : e1_reg;
        end
    end
endmodule
`default_nettype wire

[dv/incremental_pid_drive_unit_test.sv]
// Self-checking testbench for the incremental PID drive unit.
`default_nettype none
module incremental_pid_drive_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 1000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic restart = 1'b0;
    logic signed [31:0] target_rate = '0;
    logic signed [31:0] measured_rate = '0;
    logic [15:0] elapsed_ms = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [ipd_pkg::DRIVE_BITS-1:0] drive;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    incremental_pid_drive_unit dut (.*);

    always #1 clk = ~clk;

    // predictor copy of registers and loop state
    logic signed [31:0] kp, ki, kd;
    logic [15:0] start_code;
    logic signed [31:0] err1, err2;
    logic [ipd_pkg::ACC_W-1:0] accum;
    logic [ipd_pkg::DRIVE_BITS-1:0] drive_expected[$];

    int mismatches = 0;
    int cycles = 0;
    int hold_left = 0;
    bit quiet = 1'b0;
    int burst_left = 0;
    int run_left = 0;
    bit run_stall = 1'b0;

    task automatic report(input string what);
        $display("MISMATCH @%0d: %s", cycles, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // check each delivered drive against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_expected.size() == 0)
                report($sformatf("unexpected drive %0d", drive));
            else
            begin
                logic [ipd_pkg::DRIVE_BITS-1:0] want;
                want = drive_expected.pop_front();
                if (drive !== want)
                    report($sformatf("drive %0d, expected %0d", drive, want));
            end
        end
    end

    // receiver stall pattern, with a long hold when asked
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(1, 20);
                run_stall = ($urandom_range(0, 9) < 3);
            end
            run_left--;
            out_stall <= run_stall;
        end
    end

    task automatic predict_drive(input logic rs, input logic signed [31:0] tr,
                                 input logic signed [31:0] mr, input logic [15:0] el);
        longint e0, t, dq;
        logic signed [127:0] a, b, c, total, top;
        if (rs)
        begin
            err1 = '0;
            err2 = '0;
            accum = {start_code, 16'h0};
        end
        else
        begin
            e0 = longint'(tr) - longint'(mr);
            if (e0 > 64'sd2147483647) e0 = 64'sd2147483647;
            if (e0 < -64'sd2147483648) e0 = -64'sd2147483648;
            t = (el == 0) ? 1 : longint'(el);
            dq = longint'(kd) / t;
            a = longint'(kp) + dq;
            b = -longint'(kp) + longint'(ki) * t - 2 * dq;
            c = dq;
            top = $signed({112'b0, ipd_pkg::DRIVE_MAX}) <<< 32;
            total = a * e0 + b * longint'(err1) + c * longint'(err2)
                  + ($signed({96'b0, accum}) <<< 16);
            if (total < 0)
                accum = '0;
            else if (total > top)
                accum = {ipd_pkg::DRIVE_MAX, 16'h0};
            else
                accum = total[47:16];
            err2 = err1;
            err1 = e0[31:0];
        end
        drive_expected.push_back(accum[ipd_pkg::ACC_W-1:16]);
    endtask

    task automatic send_item(input logic rs, input logic signed [31:0] tr,
                             input logic signed [31:0] mr, input logic [15:0] el);
        if (!quiet)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                in_valid = 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
            burst_left--;
        end
        in_valid = 1'b1;
        restart = rs;
        target_rate = tr;
        measured_rate = mr;
        elapsed_ms = el;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_drive(rs, tr, mr, el);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (drive_expected.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] back;
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            ipd_pkg::REG_GAIN_P: kp = value;
            ipd_pkg::REG_GAIN_I: ki = value;
            ipd_pkg::REG_GAIN_D: kd = value;
            default:             start_code = value[15:0];
        endcase
        // read back
        psel = 1'b1;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        back = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if (idx == ipd_pkg::REG_START) value = {16'h0, value[15:0]};
        if (back !== value)
            report($sformatf("reg %0d read %h, expected %h", idx, back, value));
    endtask

    task automatic set_gains(input logic [31:0] p, input logic [31:0] i,
                             input logic [31:0] d, input logic [15:0] s);
        write_reg(ipd_pkg::REG_GAIN_P, p);
        write_reg(ipd_pkg::REG_GAIN_I, i);
        write_reg(ipd_pkg::REG_GAIN_D, d);
        write_reg(ipd_pkg::REG_START, {16'h0, s});
    endtask

    function automatic logic [31:0] pick_gain();
        if ($urandom_range(0, 7) == 0) return $urandom();
        return $urandom_range(0, 32'h40000) - 32'h20000;
    endfunction

    task automatic random_item();
        logic signed [31:0] tr, mr;
        logic [15:0] el;
        if ($urandom_range(0, 15) == 0)
        begin
            tr = $urandom();
            mr = $urandom();
            el = 16'($urandom());
        end
        else
        begin
            tr = $urandom_range(0, 32'h200000) - 32'h100000;
            mr = tr + ($urandom_range(0, 32'h40000) - 32'h20000);
            el = 16'($urandom_range(0, 20));
        end
        send_item($urandom_range(0, 24) == 0, tr, mr, el);
    endtask

    task automatic test_reset_values();
        send_item(1'b0, 32'sh10000, 32'sh0, 16'd1);
        send_item(1'b0, -32'sh10000, 32'sh0, 16'd0);
        send_item(1'b1, 32'sh0, 32'sh0, 16'd0);
        wait_drain();
    endtask

    task automatic test_directed();
        set_gains(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF);
        send_item(1'b1, 32'sh7FFFFFFF, 32'sh80000000, 16'hFFFF);
        // error overflow both ways, zero and largest elapsed time
        send_item(1'b0, 32'sh7FFFFFFF, 32'sh80000000, 16'd0);
        send_item(1'b0, 32'sh80000000, 32'sh7FFFFFFF, 16'hFFFF);
        send_item(1'b0, 32'sh7FFFFFFF, 32'sh80000000, 16'd1);
        send_item(1'b0, 32'sh0, 32'sh0, 16'd0);
        wait_drain();
        set_gains(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h0000);
        send_item(1'b1, 32'sh0, 32'sh0, 16'd5);
        send_item(1'b0, 32'sh80000000, 32'sh7FFFFFFF, 16'd0);
        send_item(1'b0, 32'sh7FFFFFFF, 32'sh80000000, 16'hFFFF);
        send_item(1'b0, -32'sh1, 32'sh1, 16'd2);
        wait_drain();
        set_gains(32'h00010000, 32'h00000800, 32'h00004000, 16'h8000);
        send_item(1'b1, 32'sh0, 32'sh0, 16'd0);
        send_item(1'b0, 32'sh00050000, 32'sh00040000, 16'd0);
        send_item(1'b0, 32'sh00050000, 32'sh00060000, 16'd3);
        send_item(1'b0, 32'sh00050000, 32'sh00050000, 16'd10);
        send_item(1'b0, -32'sh00080000, 32'sh00050000, 16'd1);
        wait_drain();
    endtask

    task automatic test_back_pressure();
        quiet = 1'b1;
        set_gains(32'h00008000, 32'h00000400, 32'h00002000, 16'h1234);
        hold_left = 600;
        send_item(1'b1, 32'sh0, 32'sh0, 16'd0);
        repeat (30) random_item();
        quiet = 1'b0;
        wait_drain();
    endtask

    task automatic test_random_steps();
        for (int phase = 0; phase < 10; phase++)
        begin
            set_gains(pick_gain(), pick_gain(), pick_gain(), 16'($urandom()));
            quiet = (phase == 3);
            send_item(1'b1, $urandom(), $urandom(), 16'($urandom()));
            repeat (150) random_item();
            quiet = 1'b0;
            wait_drain();
        end
    endtask

    initial
    begin
        kp = '0; ki = '0; kd = '0; start_code = '0;
        err1 = '0; err2 = '0; accum = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_values();
        test_directed();
        test_back_pressure();
        test_random_steps();
        wait_drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
hdl/ipd_pkg.sv
hdl/ipd_ctrl.sv
hdl/ipd_dp.sv
hdl/incremental_pid_drive_unit.sv
dv/incremental_pid_drive_unit_test.sv
